@@ hdl/sdspi_pkg.sv @@
// Shared types and constants for the SD card SPI-mode command engine.
// Used by sdspi_core, sd_spi_command_response_engine_top and sdspi_checker; no dependencies.
`default_nettype none
package sdspi_pkg;

	localparam logic       MODE_START = 1'b0;
	localparam logic       MODE_RX    = 1'b1;

	localparam logic [1:0] KIND_R1_ANY   = 2'd0;
	localparam logic [1:0] KIND_R1_MATCH = 2'd1;
	localparam logic [1:0] KIND_R3       = 2'd2;
	localparam logic [1:0] KIND_R7       = 2'd3;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HUNT   = 2'd1;
	localparam logic [1:0] PH_GATHER = 2'd2;

	localparam logic       REG_POLL_LIMIT  = 1'b0;
	localparam logic       REG_RETRY_LIMIT = 1'b1;

	localparam logic [7:0] POLL_LIMIT_RST  = 8'd10;
	localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;

	localparam logic [7:0] CMD_START_BITS = 8'h40;
	localparam logic [7:0] CRC_CMD55      = 8'h65;
	localparam logic [7:0] CRC_CMD41      = 8'h77;
	localparam logic [7:0] CRC_DEFAULT    = 8'h95;
	localparam logic [7:0] R7_R1_MASK     = 8'hC0;
	localparam logic [7:0] R1_ANY_MASK    = 8'h80;
	localparam logic [7:0] DUMMY_BYTE     = 8'hFF;
	localparam logic [7:0] R1_IDLE        = 8'h01;
	localparam logic [5:0] CMD_APP        = 6'd55;
	localparam logic [5:0] CMD_OP_COND    = 6'd41;

	localparam int         FRAME_BYTES = 6;
	localparam logic [2:0] FRAME_LAST  = 3'd5;

	// One queued output burst: either a six-byte command frame or a single word.
	typedef struct packed {
		logic                               is_frame;
		logic [FRAME_BYTES-1:0][7:0]        frame;
		logic [7:0]                         tx_byte;
		logic                               tx_valid;
		logic [1:0]                         status;
		logic [7:0]                         r1_value;
		logic [31:0]                        payload;
	} res_t;

endpackage
`default_nettype wire

@@ hdl/sd_spi_command_response_engine_top.sv @@
// Top level of the SD card SPI-mode command engine: configuration registers,
// the sequencer and the output register that plays out each burst.
// Depends on sdspi_pkg and sdspi_core.
//
// Each input word is processed in the cycle it is accepted, and its results are
// loaded into one output register that shows the first of them in the next cycle.
// A new input word is accepted while that register is empty, or in the cycle its
// last word is taken. Single-word results therefore allow one input word per
// cycle while out_ready stays high, and a low out_ready stalls the input. A
// command frame, sent on a start and on every resend, is six output words, one
// per cycle while out_ready is high. The word that sends a frame holds the output
// until its last frame byte is taken, in which cycle the next input word is
// accepted. A card word received while idle is accepted and produces no output.
`default_nettype none
module sd_spi_command_response_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [5:0]  cmd_index,
	input  wire logic [31:0] argument,
	input  wire logic [1:0]  response_kind,
	input  wire logic [7:0]  expected_r1,
	input  wire logic [7:0]  crc_byte,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       tx_byte,
	output logic             tx_valid,
	output logic             last,
	output logic [1:0]       status,
	output logic [7:0]       r1_value,
	output logic [31:0]      payload
);
	import sdspi_pkg::*;

	logic [7:0] poll_limit_q;
	logic [3:0] retry_limit_q;
	logic       accept;
	logic       load;
	res_t       res;
	res_t       res_s1;
	logic       valid_s1;
	logic [2:0] beat_q;
	logic       final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q  <= POLL_LIMIT_RST;
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLL_LIMIT:  poll_limit_q  <= cfg_data;
				REG_RETRY_LIMIT: retry_limit_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign final_beat = !res_s1.is_frame || beat_q == FRAME_LAST;
	assign in_ready   = !valid_s1 || (out_ready && final_beat);
	assign accept     = in_valid && in_ready;

	sdspi_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mode          (mode),
		.cmd_index     (cmd_index),
		.argument      (argument),
		.response_kind (response_kind),
		.expected_r1   (expected_r1),
		.crc_byte      (crc_byte),
		.rx_byte       (rx_byte),
		.poll_limit    (poll_limit_q),
		.retry_limit   (retry_limit_q),
		.load          (load),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_q   <= 3'd0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			beat_q   <= 3'd0;
		end else if (valid_s1 && out_ready) begin
			if (final_beat) begin
				valid_s1 <= 1'b0;
			end else begin
				beat_q <= beat_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else if (load) begin
			res_s1 <= res;
		end
	end

	assign out_valid = valid_s1;
	assign tx_byte   = res_s1.is_frame ? res_s1.frame[beat_q] : res_s1.tx_byte;
	assign tx_valid  = res_s1.is_frame ? 1'b1 : res_s1.tx_valid;
	assign last      = final_beat;
	assign status    = res_s1.is_frame ? ST_BUSY : res_s1.status;
	assign r1_value  = res_s1.is_frame ? 8'd0 : res_s1.r1_value;
	assign payload   = res_s1.is_frame ? 32'd0 : res_s1.payload;

endmodule
`default_nettype wire

@@ hdl/sdspi_core.sv @@
// Command sequencer of the SD SPI engine: holds the command context and
// the hunt/gather state, and turns each accepted word into an output burst;
// a card word while idle gives none. Depends on sdspi_pkg.
`default_nettype none
module sdspi_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic          mode,
	input  wire logic [5:0]    cmd_index,
	input  wire logic [31:0]   argument,
	input  wire logic [1:0]    response_kind,
	input  wire logic [7:0]    expected_r1,
	input  wire logic [7:0]    crc_byte,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [7:0]    poll_limit,
	input  wire logic [3:0]    retry_limit,
	output logic               load,
	output sdspi_pkg::res_t    res
);
	import sdspi_pkg::*;

	logic [1:0]  phase_q, phase_d;
	logic [1:0]  kind_q, kind_d;
	logic [5:0]  cmd_q, cmd_d;
	logic [31:0] arg_q, arg_d;
	logic [7:0]  crc_q, crc_d;
	logic [7:0]  exp_q, exp_d;
	logic [7:0]  polls_q, polls_d;
	logic [3:0]  tries_q, tries_d;
	logic [7:0]  r1_q, r1_d;
	logic [31:0] shift_q, shift_d;
	logic [2:0]  count_q, count_d;

	logic [7:0]  polls_init;
	logic [3:0]  sends;
	logic [7:0]  polls_dec;
	logic [31:0] shift_next;
	logic [2:0]  count_next;
	logic        ok;
	logic        done_ok;

	function automatic res_t make_frame(logic [5:0] cmd, logic [31:0] arg, logic [1:0] kind,
			logic [7:0] crc);
		res_t r;
		logic [7:0] c;
		r = '0;
		if (kind == KIND_R3 || kind == KIND_R7) begin
			c = crc;
		end else if (cmd == CMD_APP) begin
			c = CRC_CMD55;
		end else if (cmd == CMD_OP_COND) begin
			c = CRC_CMD41;
		end else begin
			c = CRC_DEFAULT;
		end
		r.is_frame = 1'b1;
		r.frame[0] = CMD_START_BITS | {2'b00, cmd};
		r.frame[1] = arg[31:24];
		r.frame[2] = arg[23:16];
		r.frame[3] = arg[15:8];
		r.frame[4] = arg[7:0];
		r.frame[5] = c;
		return r;
	endfunction

	function automatic res_t make_word(logic [7:0] tx, logic txv, logic [1:0] st,
			logic [7:0] r1, logic [31:0] pl);
		res_t r;
		r = '0;
		r.tx_byte  = tx;
		r.tx_valid = txv;
		r.status   = st;
		r.r1_value = r1;
		r.payload  = pl;
		return r;
	endfunction

	assign polls_init = (poll_limit != 8'd0) ? poll_limit : 8'd1;
	assign sends      = (retry_limit != 4'd0) ? retry_limit : 4'd1;
	assign polls_dec  = (polls_q != 8'd0) ? polls_q - 8'd1 : 8'd0;
	assign shift_next = {shift_q[23:0], rx_byte};
	assign count_next = count_q + 3'd1;

	always_comb begin
		case (kind_q)
			KIND_R1_ANY: ok = (rx_byte & R1_ANY_MASK) == 8'd0;
			KIND_R7:     ok = (rx_byte & R7_R1_MASK) == 8'd0;
			default:     ok = rx_byte == exp_q;
		endcase
	end

	assign done_ok = (kind_q == KIND_R7) ? (r1_q == R1_IDLE && shift_next == arg_q)
	                                     : (r1_q == exp_q);

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		cmd_d   = cmd_q;
		arg_d   = arg_q;
		crc_d   = crc_q;
		exp_d   = exp_q;
		polls_d = polls_q;
		tries_d = tries_q;
		r1_d    = r1_q;
		shift_d = shift_q;
		count_d = count_q;
		load    = 1'b0;
		res     = make_word(DUMMY_BYTE, 1'b1, ST_BUSY, 8'd0, 32'd0);
		if (accept) begin
			if (mode == MODE_START) begin
				kind_d  = response_kind;
				cmd_d   = cmd_index;
				arg_d   = argument;
				crc_d   = crc_byte;
				exp_d   = expected_r1;
				tries_d = sends - 4'd1;
				r1_d    = 8'd0;
				shift_d = 32'd0;
				count_d = 3'd0;
				polls_d = polls_init;
				phase_d = PH_HUNT;
				load    = 1'b1;
				res     = make_frame(cmd_index, argument, response_kind, crc_byte);
			end else begin
				case (phase_q)
					PH_HUNT: begin
						load    = 1'b1;
						polls_d = polls_dec;
						if (kind_q == KIND_R1_ANY || kind_q == KIND_R1_MATCH) begin
							if (ok) begin
								res     = make_word(8'd0, 1'b0, ST_OK, rx_byte, 32'd0);
								phase_d = PH_IDLE;
							end else if (polls_dec == 8'd0) begin
								res     = make_word(8'd0, 1'b0, ST_FAIL, rx_byte, 32'd0);
								phase_d = PH_IDLE;
							end
						end else if (!ok && polls_dec != 8'd0) begin
							// Keep polling; the default word is a dummy.
						end else if (!ok && tries_q != 4'd0) begin
							tries_d = tries_q - 4'd1;
							polls_d = polls_init;
							res     = make_frame(cmd_q, arg_q, kind_q, crc_q);
						end else begin
							// Either a match or the last send ran out: gather the tail.
							r1_d    = rx_byte;
							shift_d = 32'd0;
							count_d = 3'd0;
							phase_d = PH_GATHER;
						end
					end
					PH_GATHER: begin
						load    = 1'b1;
						shift_d = shift_next;
						count_d = count_next;
						if (count_next >= 3'd4) begin
							res     = make_word(8'd0, 1'b0, done_ok ? ST_OK : ST_FAIL, r1_q,
								shift_next);
							phase_d = PH_IDLE;
						end
					end
					default: begin
						// A card word while idle is dropped.
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= 2'd0;
			cmd_q   <= 6'd0;
			arg_q   <= 32'd0;
			crc_q   <= 8'd0;
			exp_q   <= 8'd0;
			polls_q <= 8'd0;
			tries_q <= 4'd0;
			r1_q    <= 8'd0;
			shift_q <= 32'd0;
			count_q <= 3'd0;
		end else begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			cmd_q   <= cmd_d;
			arg_q   <= arg_d;
			crc_q   <= crc_d;
			exp_q   <= exp_d;
			polls_q <= polls_d;
			tries_q <= tries_d;
			r1_q    <= r1_d;
			shift_q <= shift_d;
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/sdspi_checker.sv @@
// Port-level checks for the SD SPI command engine, bound to its top level.
// Depends on sdspi_pkg and on sd_spi_command_response_engine_top through the bind.
`default_nettype none
module sdspi_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        mode,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  tx_byte,
	input wire logic        tx_valid,
	input wire logic        last,
	input wire logic [1:0]  status
);
	import sdspi_pkg::*;

	// A stalled output word must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last))
		else $error("output word changed while stalled");

	// An accepted start shows the first frame byte in the next cycle.
	a_start_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_START |=> out_valid && tx_valid
			&& tx_byte[7:6] == CMD_START_BITS[7:6] && !last)
		else $error("start did not open a command frame");

	// A closing status word is the last word and sends nothing.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_BUSY |-> last && !tx_valid)
		else $error("status word malformed");

	// Words that send nothing are always closing status words.
	a_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> (status == ST_OK || status == ST_FAIL))
		else $error("silent word without a final status");

endmodule

bind sd_spi_command_response_engine_top sdspi_checker u_sdspi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.tx_byte   (tx_byte),
	.tx_valid  (tx_valid),
	.last      (last),
	.status    (status)
);
`default_nettype wire
